### src/ascii_number_to_fixed_point_assert.svh
// ascii_number_to_fixed_point_assert.svh: assertion macros for the checker.
// Expects clk and rst_n in the scope that uses them.
`ifndef ASCII_NUMBER_TO_FIXED_POINT_ASSERT_SVH
`define ASCII_NUMBER_TO_FIXED_POINT_ASSERT_SVH

// same-cycle implication
`define ANFP_ASSERT_NOW(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("anfp assertion failed");

// next-cycle implication
`define ANFP_ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("anfp assertion failed");

`endif

### src/anfp_pkg.sv
// anfp_pkg.sv: types, constants and helper functions shared by the
// ASCII number to fixed-point parser. No dependencies.
`timescale 1ns / 1ps

package anfp_pkg;

  // accumulator width default and parser limits
  localparam int ACC_WIDTH_DEF   = 32;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int RES_W           = 32;
  localparam int POW_W           = 30;     // 10^9 fits in 30 bits
  localparam int DIV_STEPS       = RES_W;  // one quotient bit per cycle
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

  // special characters
  localparam logic [7:0] CH_H     = 8'h68;  // 'h'
  localparam logic [7:0] CH_POINT = 8'h2E;  // '.'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    valid_res;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_ABS  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } anfp_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic prep;      // latch ok flag, load shifted magnitude
    logic abs_en;    // take magnitude of signed numerator
    logic div_step;  // one restoring division step
    logic finish;    // load output register, clear token
  } anfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hex_mode;  // token closed by 'h'
    logic ok;        // token parsed so far (valid at prep)
  } anfp_sts_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h61:8'h66]: r = {1'b1, 4'(c[3:0] + 4'd9)};
      [8'h41:8'h46]: r = {1'b1, 4'(c[3:0] + 4'd9)};
      default:       r = 5'b0;
    endcase
    return r;
  endfunction

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] n);
    logic [POW_W-1:0] r;
    r = POW_W'(1);
    case (n)
      4'd0:    r = POW_W'(1);
      4'd1:    r = POW_W'(10);
      4'd2:    r = POW_W'(100);
      4'd3:    r = POW_W'(1000);
      4'd4:    r = POW_W'(10000);
      4'd5:    r = POW_W'(100000);
      4'd6:    r = POW_W'(1000000);
      4'd7:    r = POW_W'(10000000);
      4'd8:    r = POW_W'(100000000);
      4'd9:    r = POW_W'(1000000000);
      default: r = POW_W'(1);
    endcase
    return r;
  endfunction

endpackage

### src/anfp_ctrl.sv
// anfp_ctrl.sv: sequencing state machine and output valid flag.
// Depends on anfp_pkg.
`timescale 1ns / 1ps

module anfp_ctrl
  import anfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  anfp_sts_t sts,
  output anfp_cmd_t cmd
);

  anfp_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_beat;
  logic                 out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.accept   = in_beat;
    case (state_r)
      ST_IDLE: begin
        if (in_beat && in_last) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        if (!sts.ok || sts.hex_mode) state_nxt = ST_DONE;
        else                         state_nxt = ST_ABS;
      end
      ST_ABS: begin
        cmd.abs_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid: set on finish, dropped when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish)               out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/anfp_dp.sv
// anfp_dp.sv: token accumulators, scaling, restoring divider and result register.
// Depends on anfp_pkg; driven by anfp_ctrl.
`timescale 1ns / 1ps

module anfp_dp
  import anfp_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_beat_t   in_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  input  anfp_cmd_t  cmd,
  output anfp_sts_t  sts,
  output out_beat_t  out_data
);

  // configuration
  logic [4:0] frac_bits_r;

  // token state
  logic [ACC_WIDTH-1:0] hex_r, hex_nxt;
  logic [ACC_WIDTH-1:0] dec_r, dec_nxt;
  logic [3:0]           frac_digits_r, frac_digits_nxt;
  logic                 point_r, point_nxt;
  logic                 neg_r, neg_nxt;
  logic                 start_r, start_nxt;
  logic                 body_r, body_nxt;
  logic                 hex_ok_r, hex_ok_nxt;
  logic                 dec_ok_r, dec_ok_nxt;
  logic                 mode_hex_r;

  // result path
  logic                 ok_r;
  logic                 sn_neg_r;
  logic [RES_W-1:0]     dvd_r;
  logic [RES_W-1:0]     rem_r;
  logic [POW_W-1:0]     pow_r;
  out_beat_t            out_r;

  logic                 absorb;
  logic [4:0]           hd;
  logic                 is_dec_digit;
  logic [3:0]           dd;
  logic [RES_W-1:0]     hex_lo, dec_lo, hex_sh, dec_sh, num;
  logic [POW_W-1:0]     pow_sel;
  logic                 ok_now;
  logic [RES_W-1:0]     rem_sh;
  logic                 ge;
  logic [RES_W-1:0]     mag_signed;

  // final 'h' closes a hex token without being absorbed
  assign absorb       = cmd.accept && !(in_data.last && in_data.ch == CH_H);
  assign hd           = hex_digit(in_data.ch);
  assign is_dec_digit = (in_data.ch >= 8'h30) && (in_data.ch <= 8'h39);
  assign dd           = in_data.ch[3:0];

  // character absorption, both radix tracks in parallel
  always_comb begin
    hex_nxt         = hex_r;
    dec_nxt         = dec_r;
    frac_digits_nxt = frac_digits_r;
    point_nxt       = point_r;
    neg_nxt         = neg_r;
    start_nxt       = start_r;
    body_nxt        = body_r;
    hex_ok_nxt      = hex_ok_r;
    dec_ok_nxt      = dec_ok_r;
    if (cmd.finish) begin
      hex_nxt         = '0;
      dec_nxt         = '0;
      frac_digits_nxt = '0;
      point_nxt       = 1'b0;
      neg_nxt         = 1'b0;
      start_nxt       = 1'b1;
      body_nxt        = 1'b0;
      hex_ok_nxt      = 1'b1;
      dec_ok_nxt      = 1'b1;
    end else if (absorb) begin
      start_nxt = 1'b0;
      if (start_r && in_data.ch == CH_MINUS) begin
        neg_nxt = 1'b1;
      end else begin
        body_nxt = 1'b1;
        // hex track
        if (hd[4]) hex_nxt = {hex_r[ACC_WIDTH-5:0], hd[3:0]};
        else       hex_ok_nxt = 1'b0;
        // decimal track
        if (in_data.ch == CH_POINT) begin
          point_nxt = 1'b1;
        end else if (is_dec_digit) begin
          dec_nxt = (dec_r << 3) + (dec_r << 1) + ACC_WIDTH'(dd);
          if (point_r && frac_digits_r != 4'hF) frac_digits_nxt = frac_digits_r + 1'b1;
        end else begin
          dec_ok_nxt = 1'b0;
        end
      end
    end
  end

  // scaling and rounding offset
  assign hex_lo  = RES_W'(hex_r);
  assign dec_lo  = RES_W'(dec_r);
  assign hex_sh  = hex_lo << frac_bits_r;
  assign dec_sh  = dec_lo << frac_bits_r;
  assign pow_sel = pow10(frac_digits_r);
  assign num     = dec_sh + RES_W'(pow_sel[POW_W-1:1]);
  assign ok_now  = mode_hex_r ? (body_r && hex_ok_r)
                              : (body_r && dec_ok_r && frac_digits_r <= 4'(MAX_FRAC_DIGITS));

  assign sts.hex_mode = mode_hex_r;
  assign sts.ok       = ok_now;

  // restoring division step
  assign rem_sh = {rem_r[RES_W-2:0], dvd_r[RES_W-1]};
  assign ge     = rem_sh >= RES_W'(pow_r);

  // sign of the result: token minus xor sign of the numerator
  assign mag_signed = (neg_r ^ sn_neg_r) ? (~dvd_r + 1'b1) : dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_bits_r   <= '0;
      hex_r         <= '0;
      dec_r         <= '0;
      frac_digits_r <= '0;
      point_r       <= 1'b0;
      neg_r         <= 1'b0;
      start_r       <= 1'b1;
      body_r        <= 1'b0;
      hex_ok_r      <= 1'b1;
      dec_ok_r      <= 1'b1;
      mode_hex_r    <= 1'b0;
      ok_r          <= 1'b0;
      sn_neg_r      <= 1'b0;
    end else begin
      if (cfg_we) frac_bits_r <= cfg_wdata;
      hex_r         <= hex_nxt;
      dec_r         <= dec_nxt;
      frac_digits_r <= frac_digits_nxt;
      point_r       <= point_nxt;
      neg_r         <= neg_nxt;
      start_r       <= start_nxt;
      body_r        <= body_nxt;
      hex_ok_r      <= hex_ok_nxt;
      dec_ok_r      <= dec_ok_nxt;
      if (cmd.accept && in_data.last) mode_hex_r <= (in_data.ch == CH_H);
      if (cmd.prep) begin
        ok_r     <= ok_now;
        sn_neg_r <= mode_hex_r ? 1'b0 : num[RES_W-1];
      end
    end
  end

  // divider and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dvd_r <= mode_hex_r ? hex_sh : num;
      pow_r <= pow_sel;
    end else if (cmd.abs_en) begin
      if (sn_neg_r) dvd_r <= ~dvd_r + 1'b1;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[RES_W-2:0], ge};
      rem_r <= ge ? (rem_sh - RES_W'(pow_r)) : rem_sh;
    end
    if (cmd.finish) begin
      out_r.value     <= ok_r ? mag_signed : '0;
      out_r.valid_res <= ok_r;
    end
  end

  assign out_data = out_r;

endmodule

### src/ascii_number_to_fixed_point.sv
// Top level: ASCII number token to signed fixed-point value.
// Throughput: one non-final character per cycle. A final 'h' goes from PREP to
// DONE; a final decimal character passes PREP, ABS and the 32-step restoring
// divider in DIV (one quotient bit per cycle) before DONE. Input stalls
// only from the final beat until the result is loaded into the output register.
// Reset: synchronous active-low rst_n clears the token state, frac_bits to 0.
`timescale 1ns / 1ps

module ascii_number_to_fixed_point
  import anfp_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  anfp_cmd_t cmd;
  anfp_sts_t sts;

  anfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  anfp_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

### src/anfp_checker.sv
// anfp_checker.sv: port-level assertions for the parser top level, and its bind.
// Depends on anfp_pkg and ascii_number_to_fixed_point_assert.svh.
`timescale 1ns / 1ps
`include "ascii_number_to_fixed_point_assert.svh"

module anfp_checker
  import anfp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // a rejected token always reports zero
  `ANFP_ASSERT_NOW(a_invalid_is_zero, out_valid && !out_data.valid_res, out_data.value == 0)

  // stalled result beat holds
  `ANFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a final beat stops intake while the result is built
  `ANFP_ASSERT_NEXT(a_last_stalls, in_valid && in_ready && in_data.last, !in_ready)

  // a new result follows a cycle with intake closed
  `ANFP_ASSERT_NOW(a_result_after_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind ascii_number_to_fixed_point anfp_checker u_anfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
